// ===== sv/netc_pkg.sv =====
// Shared definitions for the numeric element type converter.
// Type codes, the stage control struct and small lookup functions.
// No dependencies.
package netc_pkg;

	localparam logic [3:0] T_BOOL = 4'd0;
	localparam logic [3:0] T_S8   = 4'd1;
	localparam logic [3:0] T_U8   = 4'd2;
	localparam logic [3:0] T_S16  = 4'd3;
	localparam logic [3:0] T_U16  = 4'd4;
	localparam logic [3:0] T_S32  = 4'd5;
	localparam logic [3:0] T_U32  = 4'd6;
	localparam logic [3:0] T_S64  = 4'd7;
	localparam logic [3:0] T_U64  = 4'd8;
	localparam logic [3:0] T_F32  = 4'd9;
	localparam logic [3:0] T_F64  = 4'd10;

	localparam logic [3:0] REG_SOURCE_TYPE = 4'd0;
	localparam logic [3:0] REG_TARGET_TYPE = 4'd1;

	// Control that travels with each element down the pipeline.
	typedef struct packed {
		logic [3:0]  tgt;
		logic        sign;
		logic        zero;
		logic        inf;
		logic        direct;
		logic [63:0] dres;
		logic        dflag;
	} ctl_t;

	function automatic logic [63:0] type_mask(input logic [3:0] t);
		logic [63:0] m;
		case (t)
			T_BOOL, T_S8, T_U8: m = 64'h0000_0000_0000_00ff;
			T_S16, T_U16:       m = 64'h0000_0000_0000_ffff;
			T_S32, T_U32:       m = 64'h0000_0000_ffff_ffff;
			T_S64, T_U64:       m = 64'hffff_ffff_ffff_ffff;
			default:            m = 64'h0;
		endcase
		return m;
	endfunction

	function automatic logic [3:0] type_bytes(input logic [3:0] t);
		logic [3:0] n;
		case (t)
			T_S16, T_U16:        n = 4'd2;
			T_S32, T_U32, T_F32: n = 4'd4;
			T_S64, T_U64, T_F64: n = 4'd8;
			default:             n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic logic type_signed(input logic [3:0] t);
		return (t == T_S8) || (t == T_S16) || (t == T_S32) || (t == T_S64);
	endfunction

endpackage

// ===== sv/numeric_element_type_converter.sv =====
// Top level of the numeric element type converter: five-stage pipeline.
// Depends on netc_pkg.
//
// Converts one element per clock between bool, 8/16/32/64-bit signed and unsigned
// integers, IEEE single and IEEE double, following C cast rules: integer casts wrap,
// casts to bool test for nonzero, integer to float and double to single round to
// nearest even, float to integer truncates toward zero and saturates out-of-range,
// infinite or NaN values (NaN gives 0) with invalid_flag set. A transaction is taken
// whenever start is high; busy is always low because every stage advances each cycle.
// The result sits on result_bits/result_bytes/invalid_flag with done high for one
// cycle; results leave in order. The receiver cannot stall, so none is held. Each
// element passes through the stages: unpack, two normalize stages (leading-zero
// search, 32/16/8 then 4/2/1), the alignment shift with sticky, and
// round/pack/saturate. Write source_type (index 0) and target_type (index 1) through
// the cfg port only while no element is in flight; cfg_ready is always high.
module numeric_element_type_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] source_bits,
	output logic        done,
	output logic [63:0] result_bits,
	output logic [3:0]  result_bytes,
	output logic        invalid_flag,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	import netc_pkg::*;

	// Configuration registers.
	logic [3:0] src_q, tgt_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= T_BOOL;
			tgt_q <= T_BOOL;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SOURCE_TYPE) src_q <= cfg_data;
			else if (cfg_index == REG_TARGET_TYPE) tgt_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------------
	// Unpack: split the source into sign, integer magnitude and exponent so
	// that value = mag * 2^xexp. Cases with a trivial answer (integer casts,
	// casts to bool, same-type float, NaN and infinity into floats, NaN into
	// integers, unknown target) are resolved here and ride along as direct.
	// ---------------------------------------------------------------------
	ctl_t               ctl_d;
	logic [63:0]        mag_d;
	logic signed [12:0] xexp_d;
	logic [63:0]        ival;
	logic               neg_i, nan, t_float, t_int;
	logic [7:0]         e32;
	logic [22:0]        f32;
	logic [10:0]        e64;
	logic [51:0]        f64;

	always_comb begin
		e32 = source_bits[30:23];
		f32 = source_bits[22:0];
		e64 = source_bits[62:52];
		f64 = source_bits[51:0];
		t_float = (tgt_q == T_F32) || (tgt_q == T_F64);
		t_int   = (tgt_q <= T_U64);
		case (src_q)
			T_BOOL:  ival = {63'b0, |source_bits[7:0]};
			T_S8:    ival = {{56{source_bits[7]}}, source_bits[7:0]};
			T_U8:    ival = {56'b0, source_bits[7:0]};
			T_S16:   ival = {{48{source_bits[15]}}, source_bits[15:0]};
			T_U16:   ival = {48'b0, source_bits[15:0]};
			T_S32:   ival = {{32{source_bits[31]}}, source_bits[31:0]};
			T_U32:   ival = {32'b0, source_bits[31:0]};
			T_S64:   ival = source_bits;
			T_U64:   ival = source_bits;
			default: ival = 64'b0;
		endcase
		neg_i = type_signed(src_q) && ival[63];
		nan   = 1'b0;
		ctl_d.tgt    = tgt_q;
		ctl_d.sign   = 1'b0;
		ctl_d.zero   = 1'b1;
		ctl_d.inf    = 1'b0;
		ctl_d.direct = 1'b0;
		ctl_d.dres   = 64'b0;
		ctl_d.dflag  = 1'b0;
		mag_d  = 64'b0;
		xexp_d = 13'sd0;
		if (src_q == T_F32) begin
			nan        = (e32 == 8'hff) && (f32 != 23'b0);
			ctl_d.sign = source_bits[31];
			ctl_d.inf  = (e32 == 8'hff) && (f32 == 23'b0);
			ctl_d.zero = (e32 == 8'h00) && (f32 == 23'b0);
			if (e32 == 8'h00) begin
				mag_d  = {41'b0, f32};
				xexp_d = -13'sd149;
			end else begin
				mag_d  = {40'b0, 1'b1, f32};
				xexp_d = $signed({5'b0, e32}) - 13'sd150;
			end
			if (tgt_q == T_BOOL) begin
				ctl_d.direct = 1'b1;
				ctl_d.dres   = {63'b0, nan || !ctl_d.zero};
				ctl_d.dflag  = nan;
			end else if (tgt_q == T_F32) begin
				ctl_d.direct = 1'b1;
				ctl_d.dres   = {32'b0, source_bits[31:0]};
			end else if (tgt_q == T_F64 && nan) begin
				ctl_d.direct = 1'b1;
				ctl_d.dres   = {source_bits[31], 11'h7ff, 1'b1, f32[21:0], 29'b0};
			end else if (tgt_q == T_F64 && ctl_d.inf) begin
				ctl_d.direct = 1'b1;
				ctl_d.dres   = {source_bits[31], 11'h7ff, 52'b0};
			end else if (t_int && nan) begin
				ctl_d.direct = 1'b1;
				ctl_d.dflag  = 1'b1;
			end
		end else if (src_q == T_F64) begin
			nan        = (e64 == 11'h7ff) && (f64 != 52'b0);
			ctl_d.sign = source_bits[63];
			ctl_d.inf  = (e64 == 11'h7ff) && (f64 == 52'b0);
			ctl_d.zero = (e64 == 11'h000) && (f64 == 52'b0);
			if (e64 == 11'h000) begin
				mag_d  = {12'b0, f64};
				xexp_d = -13'sd1074;
			end else begin
				mag_d  = {11'b0, 1'b1, f64};
				xexp_d = $signed({2'b0, e64}) - 13'sd1075;
			end
			if (tgt_q == T_BOOL) begin
				ctl_d.direct = 1'b1;
				ctl_d.dres   = {63'b0, nan || !ctl_d.zero};
				ctl_d.dflag  = nan;
			end else if (tgt_q == T_F64) begin
				ctl_d.direct = 1'b1;
				ctl_d.dres   = source_bits;
			end else if (tgt_q == T_F32 && nan) begin
				ctl_d.direct = 1'b1;
				ctl_d.dres   = {32'b0, source_bits[63], 8'hff, 1'b1, source_bits[50:29]};
			end else if (tgt_q == T_F32 && ctl_d.inf) begin
				ctl_d.direct = 1'b1;
				ctl_d.dres   = {32'b0, source_bits[63], 8'hff, 23'b0};
			end else if (t_int && nan) begin
				ctl_d.direct = 1'b1;
				ctl_d.dflag  = 1'b1;
			end
		end else begin
			// Integer, bool or unknown source (unknown reads as zero).
			ctl_d.sign   = neg_i;
			ctl_d.zero   = (ival == 64'b0);
			mag_d        = neg_i ? (~ival + 64'd1) : ival;
			ctl_d.direct = !t_float;
			if (tgt_q == T_BOOL) ctl_d.dres = {63'b0, ival != 64'b0};
			else ctl_d.dres = ival & type_mask(tgt_q);
		end
		if (tgt_q > T_F64) begin
			ctl_d.direct = 1'b1;
			ctl_d.dres   = 64'b0;
			ctl_d.dflag  = 1'b0;
		end
	end

	// Stage 1 registers.
	logic               v_s1;
	ctl_t               ctl_s1;
	logic [63:0]        mag_s1;
	logic signed [12:0] xexp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		ctl_s1  <= ctl_d;
		mag_s1  <= mag_d;
		xexp_s1 <= xexp_d;
	end

	// ---------------------------------------------------------------------
	// Normalize, coarse half: shift out leading zeros 32, 16, 8 at a time.
	// ---------------------------------------------------------------------
	logic [63:0] n2_a, n2_b, n2_c;
	logic [5:0]  lz2;

	always_comb begin
		lz2  = 6'd0;
		n2_a = mag_s1;
		if (n2_a[63:32] == 32'b0) begin
			n2_a   = {n2_a[31:0], 32'b0};
			lz2[5] = 1'b1;
		end
		n2_b = n2_a;
		if (n2_b[63:48] == 16'b0) begin
			n2_b   = {n2_b[47:0], 16'b0};
			lz2[4] = 1'b1;
		end
		n2_c = n2_b;
		if (n2_c[63:56] == 8'b0) begin
			n2_c   = {n2_c[55:0], 8'b0};
			lz2[3] = 1'b1;
		end
	end

	logic               v_s2;
	ctl_t               ctl_s2;
	logic [63:0]        mant_s2;
	logic [5:0]         lz_s2;
	logic signed [12:0] xexp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		ctl_s2  <= ctl_s1;
		mant_s2 <= n2_c;
		lz_s2   <= lz2;
		xexp_s2 <= xexp_s1;
	end

	// ---------------------------------------------------------------------
	// Normalize, fine half (4, 2, 1), then find the leading-bit exponent and
	// the right shift that lines the mantissa up for rounding or truncation.
	// ---------------------------------------------------------------------
	logic [63:0]        n3_a, n3_b, n3_c;
	logic [5:0]         lz3;
	logic signed [13:0] e_c, emin, psh, tmp;
	logic [6:0]         sh_c;
	logic               sub_c, ovf_c, tf3;

	always_comb begin
		lz3  = lz_s2;
		n3_a = mant_s2;
		if (n3_a[63:60] == 4'b0) begin
			n3_a   = {n3_a[59:0], 4'b0};
			lz3[2] = 1'b1;
		end
		n3_b = n3_a;
		if (n3_b[63:62] == 2'b0) begin
			n3_b   = {n3_b[61:0], 2'b0};
			lz3[1] = 1'b1;
		end
		n3_c = n3_b;
		if (!n3_c[63]) begin
			n3_c   = {n3_c[62:0], 1'b0};
			lz3[0] = 1'b1;
		end
		e_c  = {xexp_s2[12], xexp_s2} + 14'sd63 - $signed({8'b0, lz3});
		tf3  = (ctl_s2.tgt == T_F32) || (ctl_s2.tgt == T_F64);
		emin = (ctl_s2.tgt == T_F32) ? -14'sd126 : -14'sd1022;
		psh  = (ctl_s2.tgt == T_F32) ? 14'sd40 : 14'sd11;
		sub_c = 1'b0;
		tmp   = 14'sd0;
		if (tf3) begin
			sub_c = (e_c < emin);
			tmp   = sub_c ? (psh + emin - e_c) : psh;
			sh_c  = (tmp > 14'sd127) ? 7'd127 : tmp[6:0];
		end else if (e_c < 14'sd0) begin
			sh_c = 7'd127;
		end else if (e_c > 14'sd63) begin
			sh_c = 7'd0;
		end else begin
			tmp  = 14'sd63 - e_c;
			sh_c = tmp[6:0];
		end
		ovf_c = ctl_s2.inf || (!ctl_s2.zero && (e_c > 14'sd63));
	end

	logic               v_s3;
	ctl_t               ctl_s3;
	logic [63:0]        mant_s3;
	logic signed [13:0] e_s3;
	logic [6:0]         sh_s3;
	logic               sub_s3, ovf_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		ctl_s3  <= ctl_s2;
		mant_s3 <= n3_c;
		e_s3    <= e_c;
		sh_s3   <= sh_c;
		sub_s3  <= sub_c;
		ovf_s3  <= ovf_c;
	end

	// ---------------------------------------------------------------------
	// Align: shift right, keep the round bit and fold the rest into sticky.
	// ---------------------------------------------------------------------
	logic [127:0] wide;

	assign wide = {mant_s3, 64'b0} >> sh_s3;

	logic               v_s4;
	ctl_t               ctl_s4;
	logic [63:0]        q_s4;
	logic               rnd_s4, stk_s4, sub_s4, ovf_s4;
	logic signed [13:0] e_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		ctl_s4 <= ctl_s3;
		q_s4   <= wide[127:64];
		rnd_s4 <= wide[63];
		stk_s4 <= |wide[62:0];
		sub_s4 <= sub_s3;
		ovf_s4 <= ovf_s3;
		e_s4   <= e_s3;
	end

	// ---------------------------------------------------------------------
	// Round to nearest even and pack floats; saturate integer results.
	// A carry out of the mantissa runs into the exponent field by the add.
	// ---------------------------------------------------------------------
	logic [63:0]        res_c, mk, half, tmag;
	logic               flag_c, inc, ok, tsgn;
	logic signed [13:0] eb, base;
	logic [24:0]        qp32;
	logic [53:0]        qp64;
	logic [31:0]        pk32;
	logic [62:0]        pk64;

	always_comb begin
		inc    = rnd_s4 && (stk_s4 || q_s4[0]);
		mk     = type_mask(ctl_s4.tgt);
		half   = (mk >> 1) + 64'd1;
		tmag   = q_s4;
		tsgn   = type_signed(ctl_s4.tgt);
		flag_c = 1'b0;
		ok     = 1'b1;
		eb     = 14'sd0;
		base   = 14'sd0;
		qp32   = {1'b0, q_s4[23:0]} + {24'b0, inc};
		qp64   = {1'b0, q_s4[52:0]} + {53'b0, inc};
		pk32   = 32'b0;
		pk64   = 63'b0;
		res_c  = 64'b0;
		if (ctl_s4.direct) begin
			res_c  = ctl_s4.dres;
			flag_c = ctl_s4.dflag;
		end else if (ctl_s4.tgt == T_F32) begin
			eb   = e_s4 + 14'sd127;
			base = sub_s4 ? 14'sd0 : (eb - 14'sd1);
			pk32 = {1'b0, base[7:0], 23'b0} + {7'b0, qp32};
			if (ctl_s4.zero) res_c = {32'b0, ctl_s4.sign, 31'b0};
			else if (!sub_s4 && (eb >= 14'sd255)) res_c = {32'b0, ctl_s4.sign, 8'hff, 23'b0};
			else res_c = {32'b0, ctl_s4.sign, pk32[30:0]};
		end else if (ctl_s4.tgt == T_F64) begin
			eb   = e_s4 + 14'sd1023;
			base = sub_s4 ? 14'sd0 : (eb - 14'sd1);
			pk64 = {base[10:0], 52'b0} + {9'b0, qp64};
			if (ctl_s4.zero) res_c = {ctl_s4.sign, 63'b0};
			else if (!sub_s4 && (eb >= 14'sd2047)) res_c = {ctl_s4.sign, 11'h7ff, 52'b0};
			else res_c = {ctl_s4.sign, pk64};
		end else if (tsgn) begin
			ok = !ovf_s4 && (ctl_s4.sign ? (tmag <= half) : (tmag < half));
			if (ok) res_c = (ctl_s4.sign ? (~tmag + 64'd1) : tmag) & mk;
			else res_c = ctl_s4.sign ? half : ((half - 64'd1) & mk);
			flag_c = !ok;
		end else begin
			ok = !ovf_s4 && (ctl_s4.sign ? (tmag == 64'b0) : ((tmag & ~mk) == 64'b0));
			if (ok) res_c = tmag;
			else res_c = ctl_s4.sign ? 64'b0 : mk;
			flag_c = !ok;
		end
	end

	logic        v_s5;
	logic [3:0]  tgt_s5;
	logic [63:0] res_s5;
	logic        flag_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		tgt_s5  <= ctl_s4.tgt;
		res_s5  <= res_c;
		flag_s5 <= flag_c;
	end

	// Present the result for one cycle.
	assign done         = v_s5;
	assign result_bits  = res_s5;
	assign result_bytes = type_bytes(tgt_s5);
	assign invalid_flag = flag_s5;

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("accepted element did not complete in five cycles");

	a_flag_int_only: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && flag_s5) |-> (tgt_s5 <= T_U64))
		else $error("invalid flag raised on a float or unknown target");

	a_f32_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && (tgt_s5 == T_F32)) |-> (res_s5[63:32] == 32'b0))
		else $error("single result has upper bits set");

	a_width_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && (tgt_s5 <= T_U64) && (tgt_s5 != T_BOOL))
		|-> ((res_s5 & ~type_mask(tgt_s5)) == 64'b0))
		else $error("integer result exceeds target width");
`endif

endmodule
